// File: hdl/srtq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srtq_pkg
// Types and constants of the sorted repeating timer queue.
// ----------------------------------------------------------------------------
package srtq_pkg;

  localparam int Capacity   = 16;
  localparam int MaxFires   = 16;
  localparam int TimeBits   = 48;
  localparam int HandleBits = 4;
  localparam int FireBits   = $clog2(MaxFires + 1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_FIRE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } chain_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_REM,
    ST_TCHK,
    ST_TINS
  } state_e;

  typedef struct packed {
    logic [1:0]            command;
    logic [HandleBits-1:0] handle;
    logic [TimeBits-1:0]   now_time;
    logic [31:0]           period;
    logic signed [15:0]    repeat_count;
  } req_t;

  typedef struct packed {
    logic                  result_kind;
    logic [1:0]            status;
    logic [HandleBits-1:0] out_handle;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic                  valid;
    logic [HandleBits-1:0] handle;
    logic [TimeBits-1:0]   expiry;
    logic [31:0]           interval;
    logic signed [15:0]    repeats;
  } entry_t;

  typedef struct packed {
    chain_op_e             op;
    entry_t                ent;
    logic [HandleBits-1:0] rm_handle;
  } chain_ctrl_t;

  function automatic logic [TimeBits-1:0] sat_add(input logic [TimeBits-1:0] t,
                                                  input logic [31:0] p);
    logic [TimeBits:0] s;
    s = {1'b0, t} + {{(TimeBits + 1 - 32){1'b0}}, p};
    if (s[TimeBits]) begin
      return {TimeBits{1'b1}};
    end
    return s[TimeBits-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/srtq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srtq_cell
// One slot of the sorted list; shifts right on insert, left on remove.
// ----------------------------------------------------------------------------
module srtq_cell import srtq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire chain_ctrl_t ctrl_i,
  input  wire entry_t      left_i,
  input  wire entry_t      right_i,
  input  wire logic        before_i,
  input  wire logic        rm_i,
  output entry_t           ent_o,
  output logic             before_o,
  output logic             rm_o
);

  entry_t ent_q, ent_d;

  // The new entry goes ahead of an equal expiry, so the test is less-or-equal.
  assign before_o = !ent_q.valid || (ctrl_i.ent.expiry <= ent_q.expiry);
  assign rm_o     = rm_i || (ent_q.valid && ent_q.handle == ctrl_i.rm_handle);
  assign ent_o    = ent_q;

  always_comb begin
    ent_d = ent_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (before_i) begin
          ent_d = left_i;
        end else if (before_o) begin
          ent_d = ctrl_i.ent;
        end
      end
      OP_REMOVE: begin
        if (rm_o) begin
          ent_d = right_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/sorted_repeating_timer_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_repeating_timer_queue
// Timer list kept sorted in a row of cells; add, remove and tick requests.
// ----------------------------------------------------------------------------
// Add and remove each give a single result, registered from the ST_ADD or ST_REM state.
// A tick drops due timers with zero repeats and fires the rest; each firing
// timer leaves the head cell in ST_TCHK and may be reinserted in ST_TINS.
// A firing result appears when the next one is found or the tick ends.
// Reset empties the list at once; no clearing pass is needed.
module sorted_repeating_timer_queue import srtq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      result_valid_o,
  output res_t      result_o
);

  state_e state_q, state_d;
  req_t   req_q;
  entry_t ins_q, ins_d;
  logic [FireBits-1:0]   fires_q, fires_d;
  logic                  pend_v_q, pend_v_d;
  logic [HandleBits-1:0] pend_h_q, pend_h_d;
  logic [Capacity-1:0]   used_q, used_d;
  logic                  out_v_q, out_v_d;
  res_t                  out_q, out_d;

  chain_ctrl_t ctrl;
  entry_t      ents   [Capacity];
  entry_t      lefts  [Capacity];
  entry_t      rights [Capacity];
  logic        befores[Capacity];
  logic        bef_in [Capacity];
  logic        rms    [Capacity];
  logic        rm_in  [Capacity];

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i]  = '0;
      assign bef_in[i] = 1'b0;
      assign rm_in[i]  = 1'b0;
    end else begin : g_mid
      assign lefts[i]  = ents[i-1];
      assign bef_in[i] = befores[i-1];
      assign rm_in[i]  = rms[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign rights[i] = '0;
    end else begin : g_notlast
      assign rights[i] = ents[i+1];
    end
    srtq_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i   (ctrl),
      .left_i   (lefts[i]),
      .right_i  (rights[i]),
      .before_i (bef_in[i]),
      .rm_i     (rm_in[i]),
      .ent_o    (ents[i]),
      .before_o (befores[i]),
      .rm_o     (rms[i])
    );
  end

  entry_t head;
  assign head = ents[0];

  logic                  all_used;
  logic [HandleBits-1:0] free_h;
  always_comb begin
    free_h = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_h = HandleBits'(i);
      end
    end
  end
  assign all_used = &used_q;

  logic due, keep;
  assign due  = head.valid && (req_q.now_time >= head.expiry) &&
                (fires_q < FireBits'(MaxFires));
  assign keep = (ins_q.repeats > 16'sd0) || (ins_q.repeats == -16'sd1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_i.command == CMD_ADD) begin
            state_d = ST_ADD;
          end else if (req_i.command == CMD_REMOVE) begin
            state_d = ST_REM;
          end else if (req_i.command == CMD_TICK) begin
            state_d = ST_TCHK;
          end
        end
      end
      ST_ADD:  state_d = ST_IDLE;
      ST_REM:  state_d = ST_IDLE;
      ST_TCHK: begin
        if (!due) begin
          state_d = ST_IDLE;
        end else if (head.repeats != 16'sd0) begin
          state_d = ST_TINS;
        end
      end
      ST_TINS: state_d = ST_TCHK;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    ctrl      = '0;
    ctrl.op   = OP_HOLD;
    ins_d     = ins_q;
    fires_d   = fires_q;
    pend_v_d  = pend_v_q;
    pend_h_d  = pend_h_q;
    used_d    = used_q;
    out_v_d   = 1'b0;
    out_d     = out_q;
    unique case (state_q)
      ST_IDLE: begin
        fires_d  = '0;
        pend_v_d = 1'b0;
      end
      ST_ADD: begin
        out_v_d          = 1'b1;
        out_d.result_kind = KIND_ACK;
        out_d.last       = 1'b1;
        if (all_used) begin
          out_d.status     = STATUS_FULL;
          out_d.out_handle = '0;
        end else begin
          out_d.status          = STATUS_OK;
          out_d.out_handle      = free_h;
          used_d[free_h]        = 1'b1;
          ctrl.op               = OP_INSERT;
          ctrl.ent.valid        = 1'b1;
          ctrl.ent.handle       = free_h;
          ctrl.ent.expiry       = sat_add(req_q.now_time, req_q.period);
          ctrl.ent.interval     = req_q.period;
          ctrl.ent.repeats      = req_q.repeat_count;
        end
      end
      ST_REM: begin
        out_v_d           = 1'b1;
        out_d.result_kind = KIND_ACK;
        out_d.last        = 1'b1;
        out_d.out_handle  = req_q.handle;
        if (used_q[req_q.handle]) begin
          out_d.status         = STATUS_OK;
          used_d[req_q.handle] = 1'b0;
          ctrl.op              = OP_REMOVE;
          ctrl.rm_handle       = req_q.handle;
        end else begin
          out_d.status = STATUS_UNKNOWN;
        end
      end
      ST_TCHK: begin
        if (!due) begin
          // The held firing is the final result of this tick.
          out_v_d           = pend_v_q;
          out_d.result_kind = KIND_FIRE;
          out_d.status      = STATUS_OK;
          out_d.out_handle  = pend_h_q;
          out_d.last        = 1'b1;
          pend_v_d          = 1'b0;
        end else begin
          ctrl.op        = OP_REMOVE;
          ctrl.rm_handle = head.handle;
          if (head.repeats == 16'sd0) begin
            used_d[head.handle] = 1'b0;
          end else begin
            out_v_d           = pend_v_q;
            out_d.result_kind = KIND_FIRE;
            out_d.status      = STATUS_OK;
            out_d.out_handle  = pend_h_q;
            out_d.last        = 1'b0;
            pend_v_d          = 1'b1;
            pend_h_d          = head.handle;
            fires_d           = fires_q + 1'b1;
            ins_d             = head;
            ins_d.expiry      = sat_add(head.expiry, head.interval);
            if (head.repeats > 16'sd0) begin
              ins_d.repeats = head.repeats - 16'sd1;
            end
          end
        end
      end
      ST_TINS: begin
        if (keep) begin
          ctrl.op  = OP_INSERT;
          ctrl.ent = ins_q;
        end else begin
          used_d[ins_q.handle] = 1'b0;
        end
      end
      default: ctrl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fires_q  <= '0;
      pend_v_q <= 1'b0;
      used_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fires_q  <= fires_d;
      pend_v_q <= pend_v_d;
      used_q   <= used_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    ins_q    <= ins_d;
    pend_h_q <= pend_h_d;
    out_q    <= out_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = out_v_q;
  assign result_o       = out_q;

endmodule
`default_nettype wire

// File: hdl/srtq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srtq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module srtq_checker import srtq_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid_o,
  input wire res_t result_o
);

  // A result is always produced by a request that kept the block busy.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a request in progress");

  // Acknowledgements are always the only result of their request.
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.result_kind == KIND_ACK) |-> result_o.last)
    else $error("acknowledgement without last");

  // Firings carry an ok status.
  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.result_kind == KIND_FIRE) |->
    (result_o.status == STATUS_OK))
    else $error("firing with nonzero status");

  // Nothing follows the final result of a request right away.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> !result_valid_o)
    else $error("result directly after last");

endmodule

bind sorted_repeating_timer_queue srtq_checker u_srtq_checker (
  .clk_i,
  .rst_ni,
  .start,
  .busy,
  .result_valid_o,
  .result_o
);
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives add, remove and tick requests into the timer queue and checks every
// acknowledgement and firing against a behavioral copy of the sorted list.
// ----------------------------------------------------------------------------
module tb;
  import srtq_pkg::*;

  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic result_valid_o;
  res_t result_o;

  sorted_repeating_timer_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow state of the timer list.
  logic [TimeBits-1:0]   tm_expiry [Capacity];
  logic [31:0]           tm_period [Capacity];
  logic signed [15:0]    tm_reps   [Capacity];
  logic                  tm_live   [Capacity];
  logic [HandleBits-1:0] tm_order  [$];

  req_t pending_reqs [$];
  res_t expected_results [$];
  int   mismatches = 0;
  int   cycles = 0;
  logic stim_done = 1'b0;
  logic quiet_driver = 1'b0;

  function automatic logic [TimeBits-1:0] clamp_sum(logic [TimeBits-1:0] t, logic [31:0] p);
    logic [TimeBits:0] s;
    s = {1'b0, t} + (TimeBits + 1)'(p);
    return s[TimeBits] ? TimeMax : s[TimeBits-1:0];
  endfunction

  function automatic void order_insert(logic [HandleBits-1:0] h);
    int pos;
    pos = 0;
    while (pos < tm_order.size() && tm_expiry[h] > tm_expiry[tm_order[pos]]) pos++;
    tm_order.insert(pos, h);
  endfunction

  function automatic void push_result(kind_e k, status_e s, logic [HandleBits-1:0] h);
    res_t r;
    r.result_kind = k;
    r.status      = s;
    r.out_handle  = h;
    r.last        = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Applies one accepted request to the shadow list and queues its results.
  function automatic void predict_request(req_t rq);
    int first_idx, fires, slot;
    logic [HandleBits-1:0] h;
    first_idx = expected_results.size();
    case (cmd_e'(rq.command))
      CMD_ADD: begin
        slot = -1;
        for (int i = 0; i < Capacity; i++) begin
          if (!tm_live[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          push_result(KIND_ACK, STATUS_FULL, '0);
        end else begin
          h = HandleBits'(slot);
          tm_live[h]   = 1'b1;
          tm_expiry[h] = clamp_sum(rq.now_time, rq.period);
          tm_period[h] = rq.period;
          tm_reps[h]   = rq.repeat_count;
          order_insert(h);
          push_result(KIND_ACK, STATUS_OK, h);
        end
      end
      CMD_REMOVE: begin
        if (tm_live[rq.handle]) begin
          foreach (tm_order[i]) begin
            if (tm_order[i] == rq.handle) begin
              tm_order.delete(i);
              break;
            end
          end
          tm_live[rq.handle] = 1'b0;
          push_result(KIND_ACK, STATUS_OK, rq.handle);
        end else begin
          push_result(KIND_ACK, STATUS_UNKNOWN, rq.handle);
        end
      end
      CMD_TICK: begin
        fires = 0;
        while (tm_order.size() > 0 && fires < MaxFires) begin
          h = tm_order[0];
          if (rq.now_time < tm_expiry[h]) break;
          void'(tm_order.pop_front());
          if (tm_reps[h] == 0) begin
            tm_live[h] = 1'b0;
            continue;
          end
          push_result(KIND_FIRE, STATUS_OK, h);
          fires++;
          tm_expiry[h] = clamp_sum(tm_expiry[h], tm_period[h]);
          if (tm_reps[h] > 0) tm_reps[h] = tm_reps[h] - 16'sd1;
          if (tm_reps[h] > 0 || tm_reps[h] == -1) order_insert(h);
          else tm_live[h] = 1'b0;
        end
      end
      default: ;
    endcase
    if (expected_results.size() > first_idx)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // Driver: start stays high across back-to-back requests.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) predict_request(req_i);
      if (!(start && busy)) begin
        if (pending_reqs.size() > 0 && !quiet_driver
            && (cycles % 1000 > 700 || $urandom_range(99) >= 36)) begin
          req_i <= pending_reqs.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    res_t want;
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        want = expected_results.pop_front();
        if (result_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, result_o);
        end
      end
    end
    if (cycles >= CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic req_t make_req(cmd_e c, logic [HandleBits-1:0] h, logic [TimeBits-1:0] t,
                                    logic [31:0] p, logic signed [15:0] r);
    req_t q;
    q.command = c;
    q.handle = h;
    q.now_time = t;
    q.period = p;
    q.repeat_count = r;
    return q;
  endfunction

  function automatic logic [TimeBits-1:0] rand_time();
    return TimeBits'({$urandom(), $urandom()});
  endfunction

  initial begin
    logic [TimeBits-1:0] base;
    logic signed [15:0]  reps;
    logic [31:0]         per;
    int k;
    for (int i = 0; i < Capacity; i++) tm_live[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    pending_reqs.push_back(make_req(CMD_TICK, '0, '0, '0, '0));             // quiet tick
    pending_reqs.push_back(make_req(CMD_REMOVE, 4'd15, '0, '0, '0));       // unknown handle
    pending_reqs.push_back(make_req(CMD_ADD, '0, '0, '0, 16'sd0));         // zero repeats
    pending_reqs.push_back(make_req(CMD_ADD, '0, '0, '0, -16'sd1));        // forever, zero period
    pending_reqs.push_back(make_req(CMD_ADD, 4'hf, TimeMax, '1, 16'sh7fff)); // saturates
    pending_reqs.push_back(make_req(CMD_ADD, '0, 48'd5, 32'd3, -16'sd7));  // odd negative
    pending_reqs.push_back(make_req(CMD_ADD, '0, 48'd8, '0, 16'sd2));
    pending_reqs.push_back(make_req(CMD_TICK, '0, 48'd10, '0, '0));
    pending_reqs.push_back(make_req(cmd_e'(2'd3), 4'h5, TimeMax, '1, '1)); // unused command
    pending_reqs.push_back(make_req(CMD_TICK, '0, TimeMax, '0, '0));       // fire cap
    pending_reqs.push_back(make_req(CMD_REMOVE, 4'd1, '0, '0, '0));
    pending_reqs.push_back(make_req(CMD_REMOVE, 4'd1, '0, '0, '0));
    for (int i = 0; i < 17; i++)                                             // fill to full
      pending_reqs.push_back(make_req(CMD_ADD, '0, 48'd100, 32'(i), 16'sd1));
    for (int i = 0; i < 16; i++)
      pending_reqs.push_back(make_req(CMD_REMOVE, 4'(i), '0, '0, '0));

    // Random part: mostly adds and ticks around a moving time base.
    base = 48'd1000;
    for (int i = 0; i < 60; i++) begin
      k = $urandom_range(99);
      per = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(20));
      case ($urandom_range(5))
        0: reps = -16'sd1;
        1: reps = 16'($urandom());
        2: reps = 16'sd0;
        default: reps = 16'($urandom_range(4));
      endcase
      if (k < 40) begin
        pending_reqs.push_back(make_req(CMD_ADD, 4'($urandom()),
                                        ($urandom_range(19) == 0) ? rand_time() : base,
                                        per, reps));
      end else if (k < 60) begin
        pending_reqs.push_back(make_req(CMD_REMOVE, 4'($urandom()), rand_time(),
                                        $urandom(), 16'($urandom())));
      end else if (k < 95) begin
        base = base + 48'($urandom_range(15));
        pending_reqs.push_back(make_req(CMD_TICK, 4'($urandom()),
                                        ($urandom_range(19) == 0) ? rand_time() : base,
                                        $urandom(), 16'($urandom())));
      end else begin
        pending_reqs.push_back(make_req(cmd_e'(2'd3), 4'($urandom()), rand_time(),
                                        $urandom(), 16'($urandom())));
      end
    end
    // Drain anything still due.
    pending_reqs.push_back(make_req(CMD_TICK, '0, TimeMax, '0, '0));
    pending_reqs.push_back(make_req(CMD_TICK, '0, TimeMax, '0, '0));
    for (int i = 0; i < 16; i++)
      pending_reqs.push_back(make_req(CMD_REMOVE, 4'(i), '0, '0, '0));

    wait (pending_reqs.size() == 0);
    @(posedge clk_i);
    while (start || busy || expected_results.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
